[rtl/esv_pkg.sv]
package esv_pkg;
  localparam int unsigned FIELD_BITS = 32;
  localparam int unsigned WORD_BITS_DEF = 32;
  localparam int unsigned CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] REG_MODULUS = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_GENERATOR = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_PUBKEY = 2'd2;
  localparam logic [FIELD_BITS-1:0] MODULUS_RST = 32'd3;
  localparam logic [FIELD_BITS-1:0] GENERATOR_RST = 32'd2;
  localparam logic [FIELD_BITS-1:0] PUBKEY_RST = 32'd1;
endpackage

[rtl/esv_modmul.sv]
module esv_modmul #(
  parameter int unsigned WORD_BITS = esv_pkg::WORD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [WORD_BITS-1:0] a,
  input  logic [WORD_BITS-1:0] b,
  input  logic [WORD_BITS-1:0] q,
  output logic                 done,
  output logic [WORD_BITS-1:0] prod
);
  import esv_pkg::*;

  localparam int unsigned CNT_BITS = $clog2(WORD_BITS + 1);

  logic [WORD_BITS-1:0] acc_r, acc_nxt, b_r, b_nxt, a_r, a_nxt;
  logic [CNT_BITS-1:0]  cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt, done_r, done_nxt;
  logic [WORD_BITS:0]   dbl, dbl_red, sum, sum_red;
  logic [WORD_BITS-1:0] dbl_v;

  // One multiplier bit a cycle, MSB first: acc = 2*acc (+a), each step reduced.
  always_comb begin
    dbl     = {acc_r, 1'b0};
    dbl_red = (dbl >= {1'b0, q}) ? dbl - {1'b0, q} : dbl;
    dbl_v   = dbl_red[WORD_BITS-1:0];
    sum     = {1'b0, dbl_v} + {1'b0, a_r};
    sum_red = (sum >= {1'b0, q}) ? sum - {1'b0, q} : sum;
    acc_nxt  = acc_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      acc_nxt  = '0;
      a_nxt    = a;
      b_nxt    = b;
      cnt_nxt  = CNT_BITS'(WORD_BITS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      acc_nxt = b_r[WORD_BITS-1] ? sum_red[WORD_BITS-1:0] : dbl_v;
      b_nxt   = {b_r[WORD_BITS-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_BITS'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
  end

  assign done = done_r;
  assign prod = acc_r;

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r)) else $error("multiply done without work");
  a_acc_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    (done_r && q != '0) |-> (acc_r < q)) else $error("product not reduced");
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("multiplier busy at done");
endmodule

[rtl/elgamal_signature_verify.sv]
// ElGamal signature check: per transaction, v1 = generator^hash mod q and
// v2 = public_key^s1 * s1^s2 mod q are computed and compared. All work runs
// through one bit-serial modular multiplier, and the sequencer waits on each
// multiply. Each of the three exponentiations reduces its base and then takes
// up to 2*WORD_BITS multiplies, and a final product joins the halves of v2.
// One transaction at a time; a finished result waits in the output register
// while the next is taken.
// A modulus below two gives both values 0 and accepted 1.
module elgamal_signature_verify #(
  parameter int unsigned WORD_BITS = esv_pkg::WORD_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [esv_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [esv_pkg::FIELD_BITS-1:0]        cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [esv_pkg::FIELD_BITS-1:0]        in_message_hash,
  input  logic [esv_pkg::FIELD_BITS-1:0]        in_sig_first,
  input  logic [esv_pkg::FIELD_BITS-1:0]        in_sig_second,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  out_accepted,
  output logic [esv_pkg::FIELD_BITS-1:0]        out_left_value,
  output logic [esv_pkg::FIELD_BITS-1:0]        out_right_value
);
  import esv_pkg::*;

  localparam int unsigned FB = FIELD_BITS;
  localparam int unsigned W = WORD_BITS;
  localparam int unsigned EB = $clog2(W + 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RED  = 4'd1;  // base reduce: 1*base mod q
  localparam logic [3:0] S_SQ   = 4'd2;
  localparam logic [3:0] S_MUL  = 4'd3;
  localparam logic [3:0] S_FIN  = 4'd4;  // v2 = p1*p2
  localparam logic [3:0] S_WAIT = 4'd5;
  localparam logic [3:0] S_DONE = 4'd6;

  logic [FB-1:0] q_cfg_r, g_cfg_r, y_cfg_r;
  logic [3:0]    st_r, st_nxt, ret_r, ret_nxt;
  logic [1:0]    job_r, job_nxt;   // 0: g^h, 1: y^s1, 2: s1^s2
  logic [W-1:0]  q_r, g_r, y_r, s1_r, s2_r, h_r, exp_r, exp_nxt;
  logic [W-1:0]  base_r, base_nxt, acc_r, acc_nxt, v1_r, v1_nxt, p1_r, p1_nxt;
  logic [EB-1:0] bit_r, bit_nxt;
  logic          trivial_r;
  logic          mstart;
  logic [W-1:0]  ma, mb;
  logic          mdone;
  logic [W-1:0]  mprod;
  logic          ov_r, ov_nxt, oacc_r;
  logic [FB-1:0] ol_r, or_r;
  logic          in_take;
  logic [W-1:0]  one_w;
  logic [W-1:0]  q_in;

  assign one_w   = W'(1);
  assign q_in    = W'(q_cfg_r);
  assign in_stall = (st_r != S_IDLE);
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_cfg_r <= MODULUS_RST;
      g_cfg_r <= GENERATOR_RST;
      y_cfg_r <= PUBKEY_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODULUS:   q_cfg_r <= cfg_data;
        REG_GENERATOR: g_cfg_r <= cfg_data;
        REG_PUBKEY:    y_cfg_r <= cfg_data;
        default: ;
      endcase
    end
  end

  esv_modmul #(.WORD_BITS(W)) u_mul (
    .clk(clk), .rst_n(rst_n), .start(mstart), .a(ma), .b(mb), .q(q_r),
    .done(mdone), .prod(mprod)
  );

  always_comb begin
    st_nxt   = st_r;
    ret_nxt  = ret_r;
    job_nxt  = job_r;
    exp_nxt  = exp_r;
    base_nxt = base_r;
    acc_nxt  = acc_r;
    v1_nxt   = v1_r;
    p1_nxt   = p1_r;
    bit_nxt  = bit_r;
    ov_nxt   = ov_r && out_stall;
    mstart   = 1'b0;
    ma       = acc_r;
    mb       = acc_r;
    unique case (st_r)
      S_IDLE: begin
        if (in_take) begin
          st_nxt  = S_RED;
          job_nxt = 2'd0;
        end
      end
      S_RED: begin
        // Reduce base: shift the whole base in as the serial operand times 1.
        mstart  = 1'b1;
        ma      = one_w;
        mb      = (job_r == 2'd0) ? g_r : (job_r == 2'd1) ? y_r : s1_r;
        exp_nxt = (job_r == 2'd0) ? h_r : (job_r == 2'd1) ? s1_r : s2_r;
        acc_nxt = one_w;
        bit_nxt = EB'(W);
        ret_nxt = S_SQ;
        st_nxt  = S_WAIT;
      end
      S_SQ: begin
        if (bit_r == '0) begin
          if (job_r == 2'd0) begin
            v1_nxt  = acc_r;
            job_nxt = 2'd1;
            st_nxt  = S_RED;
          end else if (job_r == 2'd1) begin
            p1_nxt  = acc_r;
            job_nxt = 2'd2;
            st_nxt  = S_RED;
          end else begin
            st_nxt = S_FIN;
          end
        end else begin
          mstart  = 1'b1;
          ma      = acc_r;
          mb      = acc_r;
          ret_nxt = S_MUL;
          st_nxt  = S_WAIT;
        end
      end
      S_MUL: begin
        bit_nxt = bit_r - 1'b1;
        exp_nxt = {exp_r[W-2:0], 1'b0};
        if (exp_r[W-1]) begin
          mstart  = 1'b1;
          ma      = base_r;
          mb      = acc_r;
          ret_nxt = S_SQ;
          st_nxt  = S_WAIT;
        end else begin
          st_nxt = S_SQ;
        end
      end
      S_FIN: begin
        mstart  = 1'b1;
        ma      = p1_r;
        mb      = acc_r;
        ret_nxt = S_DONE;
        st_nxt  = S_WAIT;
      end
      S_WAIT: begin
        if (mdone) begin
          st_nxt  = ret_r;
          acc_nxt = mprod;
        end
      end
      S_DONE: begin
        if (!ov_r || !out_stall) begin
          ov_nxt = 1'b1;
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  // Base capture: the multiply started in S_RED returns the reduced base.
  logic red_pend_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= S_IDLE;
      ov_r       <= 1'b0;
      red_pend_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
      if (st_r == S_RED) red_pend_r <= 1'b1;
      else if (st_r == S_WAIT && mdone) red_pend_r <= 1'b0;
    end
    ret_r <= ret_nxt;
    job_r <= job_nxt;
    exp_r <= exp_nxt;
    bit_r <= bit_nxt;
    v1_r  <= v1_nxt;
    p1_r  <= p1_nxt;
    if (st_r == S_WAIT && mdone && red_pend_r) begin
      base_r <= mprod;
      acc_r  <= (q_r == one_w) ? '0 : one_w;
    end else begin
      base_r <= base_nxt;
      acc_r  <= acc_nxt;
    end
    if (in_take) begin
      q_r       <= q_in;
      g_r       <= W'(g_cfg_r);
      y_r       <= W'(y_cfg_r);
      h_r       <= W'(in_message_hash);
      s1_r      <= W'(in_sig_first);
      s2_r      <= W'(in_sig_second);
      trivial_r <= (q_in < W'(2));
    end
    if (st_r == S_DONE && (!ov_r || !out_stall)) begin
      ol_r   <= trivial_r ? '0 : FB'(v1_r);
      or_r   <= trivial_r ? '0 : FB'(acc_r);
      oacc_r <= trivial_r ? 1'b1 : (v1_r == acc_r);
    end
  end

  assign out_valid       = ov_r;
  assign out_accepted    = oacc_r;
  assign out_left_value  = ol_r;
  assign out_right_value = or_r;

  a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != S_IDLE) |-> in_stall) else $error("input taken while busy");
  a_start_only_idle_mul: assert property (@(posedge clk) disable iff (!rst_n)
    mstart |-> (st_r != S_WAIT && st_r != S_IDLE)) else $error("bad multiply start");
  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    mdone |-> (st_r == S_WAIT)) else $error("multiply result unused");
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    ($rose(ov_r)) |-> $past(st_r == S_DONE)) else $error("result from nowhere");
endmodule
